### hw/rtl/mptt_pkg.sv
`default_nettype none

package mptt_pkg;

  // Default number of slots in a section
  localparam int unsigned SlotCountDefault = 256;

  // Reserved characters of the compacted markup text
  localparam logic [7:0] CharLt    = 8'h3C;  // '<'
  localparam logic [7:0] CharGt    = 8'h3E;  // '>'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] CharEq    = 8'h3D;  // '='
  localparam logic [7:0] CharSpace = 8'h20;  // ' '

  // Element state of a slot
  typedef enum logic [2:0] {
    ELEM_NONE         = 3'd0,
    ELEM_OPEN         = 3'd1,
    ELEM_CLOSE        = 3'd2,
    ELEM_CLOSE_OPEN   = 3'd3,
    ELEM_DOUBLE_CLOSE = 3'd4
  } elem_state_t;

  // Attribute and children section state
  typedef enum logic [1:0] {
    SEC_NONE  = 2'd0,
    SEC_OPEN  = 2'd1,
    SEC_CLOSE = 2'd2
  } sec_state_t;

  // One result item
  typedef struct packed {
    logic        slot_overflow;
    sec_state_t  children_state;
    logic        children_write;
    sec_state_t  params_state;
    logic        params_write;
    elem_state_t element_state;
    logic        element_write;
    logic [7:0]  slot_index;
  } result_t;

  function automatic logic is_reserved(input logic [7:0] c);
    is_reserved = (c == CharLt) || (c == CharGt) || (c == CharSlash) ||
                  (c == CharEq) || (c == CharSpace);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mptt_core.sv
`default_nettype none

module mptt_core #(
  parameter int unsigned SLOT_COUNT = mptt_pkg::SlotCountDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        char_in,
  input  wire logic              section_start,
  output mptt_pkg::result_t      result
);
  import mptt_pkg::*;

  localparam int unsigned SlotW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOT_COUNT - 1);

  // Running state
  logic [SlotW-1:0] slot_cnt, slot_cnt_next;
  logic             name_run, name_run_next;
  logic [7:0]       prev_char;
  logic             params_open, params_open_next;
  logic             children_open, children_open_next;
  elem_state_t      elem_state, elem_state_next;

  // State as seen by this item: section start clears it first
  logic [SlotW-1:0] cur_slot;
  logic             cur_run;
  logic [7:0]       cur_prev;
  logic             cur_params;
  logic             cur_children;
  elem_state_t      cur_elem;
  logic [SlotW+7:0] slot_ext;

  always_comb begin
    cur_slot     = section_start ? '0 : slot_cnt;
    cur_run      = section_start ? 1'b0 : name_run;
    cur_prev     = section_start ? 8'h00 : prev_char;
    cur_params   = section_start ? 1'b0 : params_open;
    cur_children = section_start ? 1'b0 : children_open;
    cur_elem     = section_start ? ELEM_NONE : elem_state;
  end

  // Per-character decode
  always_comb begin
    slot_cnt_next      = cur_slot;
    name_run_next      = cur_run;
    params_open_next   = cur_params;
    children_open_next = cur_children;
    elem_state_next    = cur_elem;
    result             = '0;

    if (is_reserved(char_in)) begin
      // end of a name run advances the slot, or flags overflow at the last slot
      if (cur_run) begin
        name_run_next = 1'b0;
        if (cur_slot < SlotLast) begin
          slot_cnt_next   = cur_slot + SlotW'(1);
          elem_state_next = ELEM_NONE;
        end else begin
          result.slot_overflow = 1'b1;
        end
      end
      priority if (char_in == CharLt) begin
        elem_state_next = (elem_state_next == ELEM_CLOSE) ? ELEM_CLOSE_OPEN : ELEM_OPEN;
        result.element_write = 1'b1;
        result.element_state = elem_state_next;
      end else if (char_in == CharGt) begin
        if (cur_params) begin
          result.params_write = 1'b1;
          result.params_state = SEC_CLOSE;
          params_open_next    = 1'b0;
        end
        if (cur_prev != CharSlash) begin
          result.children_write = 1'b1;
          result.children_state = SEC_OPEN;
          children_open_next    = 1'b1;
        end
      end else if (char_in == CharSlash) begin
        elem_state_next = (elem_state_next == ELEM_CLOSE_OPEN) ? ELEM_DOUBLE_CLOSE
                                                               : ELEM_CLOSE;
        result.element_write = 1'b1;
        result.element_state = elem_state_next;
        if (cur_params) begin
          result.params_write = 1'b1;
          result.params_state = SEC_CLOSE;
          params_open_next    = 1'b0;
        end
        if (cur_children) begin
          result.children_write = 1'b1;
          result.children_state = SEC_CLOSE;
          children_open_next    = 1'b0;
        end
      end else if (char_in == CharSpace) begin
        if (!cur_params) begin
          result.params_write = 1'b1;
          result.params_state = SEC_OPEN;
          params_open_next    = 1'b1;
        end
      end else begin
        // '=' writes nothing
      end
    end else begin
      name_run_next = 1'b1;
    end

    slot_ext          = {8'h00, slot_cnt_next};
    result.slot_index = slot_ext[7:0];
  end

  // State registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt      <= '0;
      name_run      <= 1'b0;
      prev_char     <= 8'h00;
      params_open   <= 1'b0;
      children_open <= 1'b0;
      elem_state    <= ELEM_NONE;
    end else if (accept) begin
      slot_cnt      <= slot_cnt_next;
      name_run      <= name_run_next;
      prev_char     <= char_in;
      params_open   <= params_open_next;
      children_open <= children_open_next;
      elem_state    <= elem_state_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mptt_outbuf.sv
`default_nettype none

module mptt_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mptt_pkg::result_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mptt_pkg::result_t      out_data
);
  import mptt_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // Take items until the skid stage holds one
  assign in_ready = !skid_valid;

  // Output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/markup_primitive_tag_tracker.sv
// The result of an accepted item is registered in the output buffer before the master side.
// Throughput: one item per cycle while m_tready is high; one decode pass per character.
// Stalls: the output register plus a skid entry take one more item after m_tready drops,
//   and s_tready is held low while the skid entry holds an item.
// Reset (rst, synchronous, active high) clears slot counter, name-run flag,
//   previous character, section flags, element state and the output buffer.
`default_nettype none

module markup_primitive_tag_tracker #(
  parameter int unsigned SLOT_COUNT = mptt_pkg::SlotCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] char_in, [8] section_start, [15:9] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [7:0] slot_index, [8] element_write,
                                      // [11:9] element_state, [12] params_write,
                                      // [14:13] params_state, [15] children_write,
                                      // [17:16] children_state, [18] slot_overflow,
                                      // [23:19] zero
);
  import mptt_pkg::*;

  logic    accept;
  result_t core_result;
  result_t out_result;

  assign accept = s_tvalid && s_tready;

  mptt_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_in      (s_tdata[7:0]),
    .section_start(s_tdata[8]),
    .result       (core_result)
  );

  mptt_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (core_result),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_result)
  );

  assign m_tdata = {5'b00000, out_result};

endmodule

`default_nettype wire

### test/markup_primitive_tag_tracker_test.sv
module markup_primitive_tag_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mptt_pkg::*;

  localparam int unsigned LastSlot = SlotCountDefault - 1;
  localparam int RandomItems = 1650;
  localparam int HoldCycles = 40;

  // one character item plus its expected result where it is typed in
  typedef struct {
    logic [7:0] ch;
    logic       start;
    logic       typed;
    result_t    want;
  } char_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] char_in, [8] section_start, [15:9] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] slot_index, [8] element_write, [11:9] element_state,
                          // [12] params_write, [14:13] params_state, [15] children_write,
                          // [17:16] children_state, [18] slot_overflow, [23:19] zero

  markup_primitive_tag_tracker DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // tag tracker state
  int unsigned slot_ctr = 0;
  logic        in_run = 1'b0;
  logic [7:0]  last_ch = 8'd0;
  logic        attr_open = 1'b0;
  logic        kids_open = 1'b0;
  elem_state_t slot_elem = ELEM_NONE;

  char_item_t feed[$];
  char_item_t directed_rows [22];
  result_t    expected_results[$];
  bit         fresh = 1'b0;
  int         phase = 0;
  int         mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_markup_char(logic [7:0] ch);
    return ch inside {CharLt, CharGt, CharSlash, CharEq, CharSpace};
  endfunction

  // expected result with write flags implied by nonzero states
  function automatic result_t res(logic [7:0] slot, elem_state_t es, sec_state_t ps,
                                  sec_state_t cs);
    result_t r;
    r = '0;
    r.slot_index     = slot;
    r.element_write  = (es != ELEM_NONE);
    r.element_state  = es;
    r.params_write   = (ps != SEC_NONE);
    r.params_state   = ps;
    r.children_write = (cs != SEC_NONE);
    r.children_state = cs;
    return r;
  endfunction

  // advance the tracker by one character and return the slot writes it causes
  function automatic result_t track_char(logic [7:0] ch, logic start);
    result_t    r;
    logic [7:0] prev;
    r = '0;
    if (start) begin
      slot_ctr  = 0;
      in_run    = 1'b0;
      last_ch   = 8'd0;
      attr_open = 1'b0;
      kids_open = 1'b0;
      slot_elem = ELEM_NONE;
    end
    prev    = last_ch;
    last_ch = ch;
    if (!is_markup_char(ch)) begin
      in_run = 1'b1;
    end else begin
      // a name run ends here: next slot, or saturate at the last one
      if (in_run) begin
        in_run = 1'b0;
        if (slot_ctr < LastSlot) begin
          slot_ctr++;
          slot_elem = ELEM_NONE;
        end else begin
          r.slot_overflow = 1'b1;
        end
      end
      case (ch)
        CharLt: begin
          slot_elem = (slot_elem == ELEM_CLOSE) ? ELEM_CLOSE_OPEN : ELEM_OPEN;
          r.element_write = 1'b1;
          r.element_state = slot_elem;
        end
        CharGt: begin
          if (attr_open) begin
            r.params_write = 1'b1;
            r.params_state = SEC_CLOSE;
            attr_open = 1'b0;
          end
          if (prev != CharSlash) begin
            r.children_write = 1'b1;
            r.children_state = SEC_OPEN;
            kids_open = 1'b1;
          end
        end
        CharSlash: begin
          slot_elem = (slot_elem == ELEM_CLOSE_OPEN) ? ELEM_DOUBLE_CLOSE : ELEM_CLOSE;
          r.element_write = 1'b1;
          r.element_state = slot_elem;
          if (attr_open) begin
            r.params_write = 1'b1;
            r.params_state = SEC_CLOSE;
            attr_open = 1'b0;
          end
          if (kids_open) begin
            r.children_write = 1'b1;
            r.children_state = SEC_CLOSE;
            kids_open = 1'b0;
          end
        end
        CharSpace: begin
          if (!attr_open) begin
            r.params_write = 1'b1;
            r.params_state = SEC_OPEN;
            attr_open = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.slot_index = slot_ctr[7:0];
    return r;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (is_markup_char(ch));
    return ch;
  endfunction

  task automatic put(logic [7:0] ch);
    char_item_t it;
    it.ch    = ch;
    it.start = fresh;
    it.typed = 1'b0;
    it.want  = '0;
    fresh = 1'b0;
    feed.push_back(it);
  endtask

  task automatic put_name(int max_len);
    repeat ($urandom_range(1, max_len)) put(name_byte());
  endtask

  // one section of mostly well-formed tags with random names, plus some noise
  task automatic build_section(int len, int max_name);
    int stop;
    stop = feed.size() + len;
    fresh = 1'b1;
    while (feed.size() < stop) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          put(CharLt);
          put_name(max_name);
          repeat ($urandom_range(0, 2)) begin
            put(CharSpace);
            put_name(max_name);
            put(CharEq);
            put_name(max_name);
          end
          if ($urandom_range(3) == 0) put(CharSlash);
          put(CharGt);
        end
        4, 5: begin
          put(CharLt);
          put(CharSlash);
          put_name(max_name);
          put(CharGt);
        end
        6, 7: put_name(2 * max_name);
        8: put(8'($urandom_range(255)));
        default: begin
          case ($urandom_range(4))
            0: put(CharLt);
            1: put(CharGt);
            2: put(CharSlash);
            3: put(CharEq);
            default: put(CharSpace);
          endcase
        end
      endcase
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[18:0]);
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("slot_index", want.slot_index, got.slot_index);
        check_field("element_write", want.element_write, got.element_write);
        check_field("element_state", want.element_state, got.element_state);
        check_field("params_write", want.params_write, got.params_write);
        check_field("params_state", want.params_state, got.params_state);
        check_field("children_write", want.children_write, got.children_write);
        check_field("children_state", want.children_state, got.children_state);
        check_field("slot_overflow", want.slot_overflow, got.slot_overflow);
        check_field("m_tdata[23:19]", 0, m_tdata[23:19]);
      end
    end
  end

  // receiver: busy, then mostly ready, then always ready after one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        case (phase)
          0: m_tready <= ($urandom_range(99) >= 80);
          1: m_tready <= ($urandom_range(99) >= 7);
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : limit
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus and sender
  initial begin : sender
    int      k;
    int      pct;
    bit      long_done;
    result_t predicted;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;

    directed_rows = '{
      '{CharGt,    1'b1, 1'b1, res(0, ELEM_NONE, SEC_NONE, SEC_OPEN)},
      '{8'hFF,     1'b0, 1'b1, res(0, ELEM_NONE, SEC_NONE, SEC_NONE)},
      '{CharSpace, 1'b0, 1'b1, res(1, ELEM_NONE, SEC_OPEN, SEC_NONE)},
      '{CharEq,    1'b0, 1'b1, res(1, ELEM_NONE, SEC_NONE, SEC_NONE)},
      '{CharGt,    1'b0, 1'b1, res(1, ELEM_NONE, SEC_CLOSE, SEC_OPEN)},
      '{CharLt,    1'b0, 1'b1, res(1, ELEM_OPEN, SEC_NONE, SEC_NONE)},
      '{CharSlash, 1'b0, 1'b1, res(1, ELEM_CLOSE, SEC_NONE, SEC_CLOSE)},
      '{CharLt,    1'b0, 1'b1, res(1, ELEM_CLOSE_OPEN, SEC_NONE, SEC_NONE)},
      '{CharSlash, 1'b0, 1'b1, res(1, ELEM_DOUBLE_CLOSE, SEC_NONE, SEC_NONE)},
      '{CharGt,    1'b0, 1'b1, res(1, ELEM_NONE, SEC_NONE, SEC_NONE)},
      '{8'h00,     1'b0, 1'b1, res(1, ELEM_NONE, SEC_NONE, SEC_NONE)},
      '{CharLt,    1'b0, 1'b1, res(2, ELEM_OPEN, SEC_NONE, SEC_NONE)},
      '{8'h78,     1'b1, 1'b1, res(0, ELEM_NONE, SEC_NONE, SEC_NONE)},
      '{CharSlash, 1'b0, 1'b0, '0},
      '{CharSlash, 1'b0, 1'b0, '0},
      '{CharSpace, 1'b0, 1'b0, '0},
      '{CharSpace, 1'b0, 1'b0, '0},
      '{CharSlash, 1'b0, 1'b0, '0},
      '{8'h7F,     1'b0, 1'b0, '0},
      '{CharEq,    1'b0, 1'b0, '0},
      '{8'h80,     1'b1, 1'b0, '0},
      '{CharGt,    1'b0, 1'b0, '0}
    };
    foreach (directed_rows[i]) feed.push_back(directed_rows[i]);

    // short sections, with one long section of names of at most two bytes to saturate the slots
    long_done = 1'b0;
    while (feed.size() < $size(directed_rows) + RandomItems) begin
      if (!long_done && feed.size() > 400) begin
        long_done = 1'b1;
        build_section(900, 1);
      end else begin
        build_section($urandom_range(8, 60), 4);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    k = 0;
    while (k < feed.size()) begin
      phase = (k * 3) / feed.size();
      pct = (phase == 0) ? 7 : (phase == 1) ? 80 : 0;
      if ($urandom_range(99) < pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, feed[k].start, feed[k].ch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = track_char(feed[k].ch, feed[k].start);
        expected_results.push_back(feed[k].typed ? feed[k].want : predicted);
        k++;
      end
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
